FILE: sv/cbr_pkg.sv
package cbr_pkg;

	localparam logic [11:0] YEAR_FIRST = 12'd2000;
	localparam logic [11:0] YEAR_LAST  = 12'd2099;
	localparam logic [3:0]  MONTH_LAST = 4'd12;
	localparam logic [4:0]  HOUR_LAST  = 5'd23;
	localparam logic [4:0]  HOUR_NOON  = 5'd12;
	localparam logic [5:0]  MINUTE_LAST = 6'd59;
	localparam logic [3:0]  HOUR12_TOP = 4'd12;
	localparam logic [7:0]  HOUR_MODE12 = 8'h80;
	localparam logic [7:0]  HOUR_PM     = 8'h20;
	localparam logic [6:0]  YOC_LAST    = 7'd99;
	localparam logic [6:0]  CENT_TERM_20 = 7'd105;
	localparam logic [6:0]  CENT_TERM_19 = 7'd99;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
	} req_t;

	typedef struct packed {
		logic [7:0] year_word;
		logic [4:0] month_word;
		logic [5:0] day_word;
		logic [7:0] hour_word;
		logic [6:0] minute_word;
		logic [2:0] weekday;
		logic       invalid;
	} rsp_t;

	typedef struct packed {
		logic       bad;
		logic [6:0] yoc;
		logic [3:0] month;
		logic [4:0] day;
		logic [3:0] h12;
		logic       pm;
		logic [5:0] minute;
		logic [6:0] k;
		logic [5:0] mterm;
		logic [6:0] jterm;
	} dec_t;

	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [13:0] p;
		logic [3:0]  tens;
		logic [6:0]  rest;
		p    = 14'(v) * 14'd103;
		tens = p[13:10];
		rest = v - 7'(tens) * 7'd10;
		return {tens, rest[3:0]};
	endfunction

	function automatic logic [5:0] month_term(input logic [3:0] m);
		logic [5:0] t;
		case (m)
			4'd3:    t = 6'd10;
			4'd4:    t = 6'd13;
			4'd5:    t = 6'd15;
			4'd6:    t = 6'd18;
			4'd7:    t = 6'd20;
			4'd8:    t = 6'd23;
			4'd9:    t = 6'd26;
			4'd10:   t = 6'd28;
			4'd11:   t = 6'd31;
			4'd12:   t = 6'd33;
			4'd13:   t = 6'd36;
			4'd14:   t = 6'd39;
			default: t = 6'd0;
		endcase
		return t;
	endfunction

	function automatic logic [2:0] mod7(input logic [8:0] x);
		logic [6:0] f1;
		logic [3:0] f2;
		logic [3:0] f3;
		f1 = 7'(x[8:3]) + 7'(x[2:0]);
		f2 = 4'(f1[6:3]) + 4'(f1[2:0]);
		f3 = 4'(f2[3]) + 4'(f2[2:0]);
		if (f3 >= 4'd7) begin
			f3 = f3 - 4'd7;
		end
		return f3[2:0];
	endfunction

endpackage

FILE: sv/cbr_decode.sv
module cbr_decode (
	input  cbr_pkg::req_t req,
	output cbr_pkg::dec_t dec
);

	logic       early;
	logic [6:0] yoc;
	logic [3:0] mshift;

	assign yoc    = 7'(req.year - cbr_pkg::YEAR_FIRST);
	assign early  = (req.month <= 4'd2);
	assign mshift = early ? req.month + 4'd12 : req.month;

	always_comb begin
		dec.bad = (req.year < cbr_pkg::YEAR_FIRST) || (req.year > cbr_pkg::YEAR_LAST) ||
			(req.month == 4'd0) || (req.month > cbr_pkg::MONTH_LAST) ||
			(req.day == 5'd0) || (req.hour > cbr_pkg::HOUR_LAST) ||
			(req.minute > cbr_pkg::MINUTE_LAST);
		dec.yoc    = yoc;
		dec.month  = req.month;
		dec.day    = req.day;
		dec.minute = req.minute;
		dec.mterm  = cbr_pkg::month_term(mshift);
		if (early && yoc == 7'd0) begin
			dec.k     = cbr_pkg::YOC_LAST;
			dec.jterm = cbr_pkg::CENT_TERM_19;
		end else if (early) begin
			dec.k     = yoc - 7'd1;
			dec.jterm = cbr_pkg::CENT_TERM_20;
		end else begin
			dec.k     = yoc;
			dec.jterm = cbr_pkg::CENT_TERM_20;
		end
		if (req.hour == 5'd0) begin
			dec.h12 = cbr_pkg::HOUR12_TOP;
			dec.pm  = 1'b0;
		end else if (req.hour < cbr_pkg::HOUR_NOON) begin
			dec.h12 = req.hour[3:0];
			dec.pm  = 1'b0;
		end else if (req.hour == cbr_pkg::HOUR_NOON) begin
			dec.h12 = cbr_pkg::HOUR12_TOP;
			dec.pm  = 1'b1;
		end else begin
			dec.h12 = 4'(req.hour - cbr_pkg::HOUR_NOON);
			dec.pm  = 1'b1;
		end
	end

endmodule

FILE: sv/calendar_to_bcd_rtc_words.sv
// Converts a binary date and 24-hour time into packed BCD clock-chip words
// (year of century, month, day, 12-hour hour word with mode and PM bits,
// minute) plus the ISO weekday from Zeller's congruence. Out-of-range
// fields give a result with invalid set and all other fields zero.
// Three register stages: range check and term decode, BCD encode and the
// congruence sum, then the mod-7 reduction into the output register.
// One request is taken every cycle while the output is not stalled, and a
// stalled output backs up through the stages without loss.
module calendar_to_bcd_rtc_words (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  cbr_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output cbr_pkg::rsp_t rsp
);

	cbr_pkg::dec_t dec;
	cbr_pkg::dec_t dec_s1;
	cbr_pkg::rsp_t words_s2;
	logic [8:0]    zsum_s2;
	cbr_pkg::rsp_t words_wd;
	cbr_pkg::rsp_t rsp_s3;
	logic          v_s1, v_s2, v_s3;
	logic          en1, en2, en3;
	logic [2:0]    h;

	cbr_decode u_decode (
		.req (req),
		.dec (dec)
	);

	assign en3 = !v_s3 || rsp_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign req_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= req_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			dec_s1 <= dec;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			zsum_s2 <= 9'(dec_s1.day) + 9'(dec_s1.mterm) + 9'(dec_s1.k) +
				9'(dec_s1.k >> 2) + 9'(dec_s1.jterm);
			words_s2.weekday <= 3'd0;
			words_s2.invalid <= dec_s1.bad;
			if (dec_s1.bad) begin
				words_s2.year_word   <= 8'd0;
				words_s2.month_word  <= 5'd0;
				words_s2.day_word    <= 6'd0;
				words_s2.hour_word   <= 8'd0;
				words_s2.minute_word <= 7'd0;
			end else begin
				words_s2.year_word   <= cbr_pkg::to_bcd(dec_s1.yoc);
				words_s2.month_word  <= 5'(cbr_pkg::to_bcd(7'(dec_s1.month)));
				words_s2.day_word    <= 6'(cbr_pkg::to_bcd(7'(dec_s1.day)));
				words_s2.hour_word   <= cbr_pkg::HOUR_MODE12 |
					(dec_s1.pm ? cbr_pkg::HOUR_PM : 8'd0) |
					cbr_pkg::to_bcd(7'(dec_s1.h12));
				words_s2.minute_word <= 7'(cbr_pkg::to_bcd(7'(dec_s1.minute)));
			end
		end
	end

	assign h = cbr_pkg::mod7(zsum_s2);

	always_comb begin
		words_wd = words_s2;
		if (words_s2.invalid) begin
			words_wd.weekday = 3'd0;
		end else if (h >= 3'd2) begin
			words_wd.weekday = h - 3'd1;
		end else begin
			words_wd.weekday = h + 3'd6;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			rsp_s3 <= words_wd;
		end
	end

	assign rsp_valid = v_s3;
	assign rsp       = rsp_s3;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.invalid |-> rsp.year_word == 8'd0 && rsp.month_word == 5'd0 &&
		rsp.day_word == 6'd0 && rsp.hour_word == 8'd0 && rsp.minute_word == 7'd0 &&
		rsp.weekday == 3'd0)
		else $error("invalid response carries nonzero fields");

	a_valid_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.invalid |-> rsp.hour_word[7] && rsp.weekday != 3'd0)
		else $error("valid response lacks mode bit or weekday");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> v_s1 && v_s2 && v_s3 && !rsp_ready)
		else $error("request stalled with a free stage");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !en3 |=> v_s2 && $stable(zsum_s2) && $stable(words_s2))
		else $error("stage two lost data under stall");

endmodule

FILE: sim/calendar_to_bcd_rtc_words_tb.sv
`timescale 1ns / 100ps

module calendar_to_bcd_rtc_words_tb;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	cbr_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	cbr_pkg::rsp_t rsp;

	cbr_pkg::rsp_t expected_words[$];
	int error_count = 0;
	int stall_cycles = 0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int hold_requests = 0;
	int hold_seen = 0;
	int hold_left = 0;

	calendar_to_bcd_rtc_words dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #1 clk = ~clk;

	function automatic logic [7:0] packed_bcd(input int unsigned v);
		return 8'(((v / 10) << 4) | (v % 10));
	endfunction

	function automatic logic [2:0] iso_day_of_week(input int unsigned y, input int unsigned m,
			input int unsigned d);
		int unsigned yy;
		int unsigned mm;
		int unsigned yoc;
		int unsigned cent;
		int unsigned h;
		yy = y;
		mm = m;
		if (mm <= 2) begin
			yy = yy - 1;
			mm = mm + 12;
		end
		yoc = yy % 100;
		cent = yy / 100;
		h = (d + (26 * (mm + 1)) / 10 + yoc + yoc / 4 + cent / 4 + 5 * cent) % 7;
		return 3'(((h + 5) % 7) + 1);
	endfunction

	function automatic cbr_pkg::rsp_t rtc_words_for(input cbr_pkg::req_t r);
		cbr_pkg::rsp_t w;
		int unsigned h12;
		bit pm;
		w = '0;
		if (r.year < cbr_pkg::YEAR_FIRST || r.year > cbr_pkg::YEAR_LAST || r.month < 1 ||
				r.month > cbr_pkg::MONTH_LAST || r.day < 1 || r.hour > cbr_pkg::HOUR_LAST ||
				r.minute > cbr_pkg::MINUTE_LAST) begin
			w.invalid = 1'b1;
			return w;
		end
		if (r.hour == 0) begin
			h12 = 12;
			pm = 1'b0;
		end else if (r.hour < cbr_pkg::HOUR_NOON) begin
			h12 = r.hour;
			pm = 1'b0;
		end else if (r.hour == cbr_pkg::HOUR_NOON) begin
			h12 = 12;
			pm = 1'b1;
		end else begin
			h12 = r.hour - 12;
			pm = 1'b1;
		end
		w.year_word = packed_bcd(r.year % 100);
		w.month_word = 5'(packed_bcd(r.month));
		w.day_word = 6'(packed_bcd(r.day));
		w.hour_word = cbr_pkg::HOUR_MODE12 | (pm ? cbr_pkg::HOUR_PM : 8'h00) |
			packed_bcd(h12);
		w.minute_word = 7'(packed_bcd(r.minute));
		w.weekday = iso_day_of_week(r.year, r.month, r.day);
		w.invalid = 1'b0;
		return w;
	endfunction

	function automatic cbr_pkg::req_t random_request();
		cbr_pkg::req_t r;
		r.year = 12'($urandom_range(2099, 2000));
		r.month = 4'($urandom_range(12, 1));
		r.day = 5'($urandom_range(31, 1));
		r.hour = 5'($urandom_range(23, 0));
		r.minute = 6'($urandom_range(59, 0));
		if ($urandom_range(99) < 15) begin
			if ($urandom_range(1)) r.year = 12'($urandom);
			if ($urandom_range(1)) r.month = 4'($urandom);
			if ($urandom_range(1)) r.day = 5'($urandom);
			if ($urandom_range(1)) r.hour = 5'($urandom);
			if ($urandom_range(1)) r.minute = 6'($urandom);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("ERROR %0t: %s", $realtime, msg);
	endtask

	task automatic compare_field(input string name, input logic [11:0] got,
			input logic [11:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
	endtask

	// one request; caller stands at a rising edge
	task automatic send_request(input cbr_pkg::req_t item);
		int gap;
		if (tx_idle_on && $urandom_range(99) < 30) begin
			gap = $urandom_range(2, 1);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		expected_words.push_back(rtc_words_for(item));
	endtask

	task automatic send_fields(input int y, input int m, input int d, input int h,
			input int mi);
		send_request(cbr_pkg::req_t'{12'(y), 4'(m), 5'(d), 5'(h), 6'(mi)});
	endtask

	task automatic wait_for_drain();
		req_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed_corners();
		send_fields(2000, 1, 1, 0, 0);
		send_fields(2099, 12, 31, 23, 59);
		send_fields(2000, 2, 29, 12, 30);
		send_fields(2000, 3, 1, 11, 1);
		send_fields(2023, 2, 31, 13, 45);
		send_fields(2024, 2, 28, 1, 9);
		send_fields(2050, 6, 15, 22, 10);
		send_fields(2001, 1, 31, 10, 58);
		send_fields(1999, 6, 1, 5, 5);
		send_fields(2100, 6, 1, 5, 5);
		send_fields(0, 0, 0, 0, 0);
		send_fields(4095, 15, 31, 31, 63);
		send_fields(2010, 0, 10, 5, 5);
		send_fields(2010, 13, 10, 5, 5);
		send_fields(2010, 5, 0, 5, 5);
		send_fields(2010, 5, 10, 24, 5);
		send_fields(2010, 5, 10, 5, 60);
		send_fields(2010, 5, 10, 5, 63);
		send_fields(2077, 7, 4, 12, 0);
		send_fields(2088, 8, 8, 0, 59);
		send_fields(2099, 2, 1, 23, 0);
		wait_for_drain();
	endtask

	task automatic test_random_requests(input int count);
		repeat (count) send_request(random_request());
		wait_for_drain();
	endtask

	task automatic test_steady_stream(input int count);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		repeat (count) send_request(random_request());
		wait_for_drain();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	task automatic test_output_backpressure(input int count);
		hold_requests++;
		repeat (count) send_request(random_request());
		wait_for_drain();
	endtask

	task automatic test_paced_bursts(input int bursts, input int burst_len);
		repeat (bursts) begin
			repeat ($urandom_range(burst_len, 1)) send_request(random_request());
			wait_for_drain();
		end
	endtask

	always @(posedge clk) begin
		if (hold_requests != hold_seen) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rsp_ready <= 1'b0;
		end else if (rx_idle_on) begin
			rsp_ready <= ($urandom_range(99) >= 30);
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cbr_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("response with no request outstanding");
			end else begin
				want = expected_words.pop_front();
				compare_field("year_word", 12'(rsp.year_word), 12'(want.year_word));
				compare_field("month_word", 12'(rsp.month_word), 12'(want.month_word));
				compare_field("day_word", 12'(rsp.day_word), 12'(want.day_word));
				compare_field("hour_word", 12'(rsp.hour_word), 12'(want.hour_word));
				compare_field("minute_word", 12'(rsp.minute_word), 12'(want.minute_word));
				compare_field("weekday", 12'(rsp.weekday), 12'(want.weekday));
				compare_field("invalid", 12'(rsp.invalid), 12'(want.invalid));
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles + 1 >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_corners();
		test_random_requests(1270);
		test_steady_stream(400);
		test_output_backpressure(60);
		test_paced_bursts(10, 40);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
